### sv/pai_pkg.sv
// Package for the polynomial area integrator: widths, register indexes,
// status codes, the sequencer state type and the structs between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pai_pkg;

  localparam int MAX_DEGREE_DEF = 5;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int STEP_W    = 16;
  localparam int DEG_W     = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_HINIT,
    S_EVAL,
    S_HMUL,
    S_PT,
    S_RMUL,
    S_TMUL,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    logic [STEP_W-1:0]        steps;
  } item_t;

  typedef struct packed {
    logic  start;
    item_t item;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WIDE_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] op_a;
    logic signed [WIDE_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WIDE_W-1:0] res;
    logic                     sat;
  } mul_rsp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [WIDE_W-1:0] rect;
    logic signed [WIDE_W-1:0] trap;
    status_t                  status;
  } result_t;

endpackage

`default_nettype wire

### sv/pai_div.sv
// Iterative step-width divider: ((b - a) << FRAC_BITS) / n, truncated toward zero.
// Restoring division, one quotient bit per cycle. Depends on pai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pai_div #(
  parameter int FRAC_BITS = pai_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pai_pkg::div_req_t req,
  output pai_pkg::div_rsp_t      rsp
);

  localparam int DW = pai_pkg::DATA_W + 1 + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam int SW = pai_pkg::STEP_W;
  localparam logic [CW-1:0] LastStep = CW'(DW - 1);

  logic                    busy_r;
  logic                    done_r;
  logic [CW-1:0]           cnt_r;
  logic [DW-1:0]           dvd_r;
  logic [SW-1:0]           rem_r;
  logic [SW-1:0]           den_r;
  logic                    neg_r;

  logic signed [pai_pkg::DATA_W:0] diff;
  logic [DW-1:0]           scaled;
  logic [DW-1:0]           mag;
  logic [SW:0]             rem_sh;
  logic [SW:0]             rem_sub;
  logic                    ge;
  logic [pai_pkg::WIDE_W-1:0] qext;

  always_comb begin
    diff    = {req.item.upper[pai_pkg::DATA_W-1], req.item.upper}
            - {req.item.lower[pai_pkg::DATA_W-1], req.item.lower};
    scaled  = {diff, {FRAC_BITS{1'b0}}};
    mag     = diff[pai_pkg::DATA_W] ? (~scaled + DW'(1)) : scaled;
    rem_sh  = {rem_r, dvd_r[DW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    qext    = {{(pai_pkg::WIDE_W - DW){1'b0}}, dvd_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LastStep) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= mag;
      rem_r <= '0;
      den_r <= req.item.steps;
      neg_r <= diff[pai_pkg::DATA_W];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? $signed(~qext + 64'd1) : $signed(qext);

endmodule

`default_nettype wire

### sv/pai_mul.sv
// Shared multiply unit: trunc(a * b / 2^FRAC_BITS) saturated to 64 bits.
// Four 32x32 partial products over successive cycles. Depends on pai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pai_mul #(
  parameter int FRAC_BITS = pai_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pai_pkg::mul_req_t req,
  output pai_pkg::mul_rsp_t      rsp
);

  localparam int W  = pai_pkg::WIDE_W;
  localparam int HW = W / 2;
  localparam logic [2:0] LastPp  = 3'd3;
  localparam logic [2:0] LastAcc = 3'd4;
  localparam logic [2:0] FinStep = 3'd5;

  logic                busy_r;
  logic                done_r;
  logic [2:0]          cnt_r;
  logic [W-1:0]        ua_r;
  logic [W-1:0]        ub_r;
  logic                neg_r;
  logic [W-1:0]        pp_r;
  logic [1:0]          pps_r;
  logic [2*W-1:0]      prod_r;
  logic signed [W-1:0] res_r;
  logic                sat_r;

  logic [HW-1:0]       half_a;
  logic [HW-1:0]       half_b;
  logic [W-1:0]        pp_val;
  logic [2*W-1:0]      pp_shift;
  logic                hi_ovf;
  logic [W-1:0]        mag_lo;
  logic                ovf;
  logic signed [W-1:0] fin_val;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  always_comb begin
    half_a = cnt_r[0] ? ua_r[W-1:HW] : ua_r[HW-1:0];
    half_b = cnt_r[1] ? ub_r[W-1:HW] : ub_r[HW-1:0];
    pp_val = half_a * half_b;
    case (pps_r)
      2'd0:    pp_shift = {{W{1'b0}}, pp_r};
      2'd1:    pp_shift = {{HW{1'b0}}, pp_r, {HW{1'b0}}};
      default: pp_shift = {pp_r, {W{1'b0}}};
    endcase
    hi_ovf = |prod_r[2*W-1:W+FRAC_BITS];
    mag_lo = prod_r[W+FRAC_BITS-1:FRAC_BITS];
    if (neg_r) begin
      ovf     = hi_ovf || (mag_lo > {1'b1, {(W-1){1'b0}}});
      fin_val = ovf ? $signed({1'b1, {(W-1){1'b0}}}) : $signed(~mag_lo + W'(1));
    end else begin
      ovf     = hi_ovf || mag_lo[W-1];
      fin_val = ovf ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(mag_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == FinStep) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua_r   <= mag(req.op_a);
      ub_r   <= mag(req.op_b);
      neg_r  <= req.op_a[W-1] ^ req.op_b[W-1];
      prod_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= LastPp) begin
        pp_r  <= pp_val;
        pps_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
      end
      if (cnt_r >= 3'd1 && cnt_r <= LastAcc) begin
        prod_r <= prod_r + pp_shift;
      end
      if (cnt_r == FinStep) begin
        res_r <= fin_val;
        sat_r <= ovf;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.sat  = sat_r;

endmodule

`default_nettype wire

### sv/pai_seq.sv
// Sequencer and accumulators: grid walk, Horner evaluation through the shared
// multiplier, rectangle and trapezoid sums. Depends on pai_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pai_seq #(
  parameter int MAX_DEGREE = pai_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = pai_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire pai_pkg::item_t                         item,
  input  wire logic [pai_pkg::DEG_W-1:0]              poly_degree,
  input  wire logic [MAX_DEGREE:0][pai_pkg::DATA_W-1:0] coef,
  output logic                                        idle,
  output pai_pkg::div_req_t                           div_req,
  input  wire pai_pkg::div_rsp_t                      div_rsp,
  output pai_pkg::mul_req_t                           mul_req,
  input  wire pai_pkg::mul_rsp_t                      mul_rsp,
  output pai_pkg::result_t                            res,
  input  wire logic                                   res_ready
);

  localparam int W      = pai_pkg::WIDE_W;
  localparam int DW     = pai_pkg::DATA_W;
  localparam int SW     = pai_pkg::STEP_W;
  localparam int CIDX_W = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam logic [pai_pkg::DEG_W-1:0] MaxDeg = pai_pkg::DEG_W'(MAX_DEGREE);

  typedef struct packed {
    logic                ovf;
    logic signed [W-1:0] val;
  } sat_sum_t;

  pai_pkg::seq_state_t state_r, state_nxt;
  logic signed [W-1:0] acc_r,   acc_nxt;
  logic signed [W-1:0] dx_r,    dx_nxt;
  logic signed [W-1:0] x_r,     x_nxt;
  logic signed [W-1:0] v_r,     v_nxt;
  logic signed [W-1:0] fprev_r, fprev_nxt;
  logic signed [W-1:0] rect_r,  rect_nxt;
  logic signed [W-1:0] trap_r,  trap_nxt;
  logic [CIDX_W-1:0]   d_r,     d_nxt;
  logic [SW-1:0]       i_r,     i_nxt;
  logic [SW-1:0]       n_r,     n_nxt;
  logic [DW-1:0]       lo_r,    lo_nxt;
  logic                sat_r,   sat_nxt;
  logic                zero_r,  zero_nxt;

  logic [CIDX_W-1:0]   deg_eff;
  logic [CIDX_W-1:0]   dm1;
  logic [W:0]          pair_sum;
  logic signed [W-1:0] avg;
  sat_sum_t            horner_add;
  sat_sum_t            rect_add;
  sat_sum_t            trap_add;

  function automatic logic signed [W-1:0] sext(input logic [DW-1:0] v);
    return $signed({{(W-DW){v[DW-1]}}, v});
  endfunction

  function automatic sat_sum_t sat_add(input logic signed [W-1:0] a,
                                       input logic signed [W-1:0] b);
    logic [W:0] s;
    sat_sum_t   r;
    s = {a[W-1], a} + {b[W-1], b};
    r.ovf = s[W] ^ s[W-1];
    if (r.ovf) begin
      r.val = s[W] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed({1'b0, {(W-1){1'b1}}});
    end else begin
      r.val = $signed(s[W-1:0]);
    end
    return r;
  endfunction

  always_comb begin
    deg_eff    = CIDX_W'((poly_degree > MaxDeg) ? MaxDeg : poly_degree);
    dm1        = d_r - CIDX_W'(1);
    pair_sum   = {fprev_r[W-1], fprev_r} + {v_r[W-1], v_r};
    avg        = $signed(pair_sum[W:1]);
    horner_add = sat_add(mul_rsp.res, sext(coef[dm1]));
    rect_add   = sat_add(rect_r, mul_rsp.res);
    trap_add   = sat_add(trap_r, mul_rsp.res);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pai_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (item.steps == '0) ? pai_pkg::S_DONE : pai_pkg::S_DIV;
        end
      end
      pai_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = pai_pkg::S_HINIT;
        end
      end
      pai_pkg::S_HINIT: state_nxt = pai_pkg::S_EVAL;
      pai_pkg::S_EVAL: begin
        state_nxt = (d_r == '0) ? pai_pkg::S_PT : pai_pkg::S_HMUL;
      end
      pai_pkg::S_HMUL: begin
        if (mul_rsp.done) begin
          state_nxt = pai_pkg::S_EVAL;
        end
      end
      pai_pkg::S_PT: begin
        state_nxt = (i_r == '0) ? pai_pkg::S_HINIT : pai_pkg::S_RMUL;
      end
      pai_pkg::S_RMUL: begin
        if (mul_rsp.done) begin
          state_nxt = pai_pkg::S_TMUL;
        end
      end
      pai_pkg::S_TMUL: begin
        if (mul_rsp.done) begin
          state_nxt = (i_r == n_r) ? pai_pkg::S_DONE : pai_pkg::S_HINIT;
        end
      end
      pai_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = pai_pkg::S_IDLE;
        end
      end
      default: state_nxt = pai_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idle          = (state_r == pai_pkg::S_IDLE);
    div_req.start = idle && start && (item.steps != '0);
    div_req.item  = item;
    mul_req.start = 1'b0;
    mul_req.op_a  = v_r;
    mul_req.op_b  = x_r;
    case (state_r)
      pai_pkg::S_EVAL: mul_req.start = (d_r != '0);
      pai_pkg::S_PT: begin
        mul_req.start = (i_r != '0);
        mul_req.op_a  = dx_r;
        mul_req.op_b  = v_r;
      end
      pai_pkg::S_RMUL: begin
        mul_req.start = mul_rsp.done;
        mul_req.op_a  = dx_r;
        mul_req.op_b  = avg;
      end
      default: mul_req.start = 1'b0;
    endcase
    res.valid = (state_r == pai_pkg::S_DONE);
    res.rect  = rect_r;
    res.trap  = trap_r;
    if (zero_r) begin
      res.status = pai_pkg::ST_ZERO;
    end else if (sat_r) begin
      res.status = pai_pkg::ST_SAT;
    end else begin
      res.status = pai_pkg::ST_OK;
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    dx_nxt    = dx_r;
    x_nxt     = x_r;
    v_nxt     = v_r;
    fprev_nxt = fprev_r;
    rect_nxt  = rect_r;
    trap_nxt  = trap_r;
    d_nxt     = d_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    lo_nxt    = lo_r;
    sat_nxt   = sat_r;
    zero_nxt  = zero_r;
    case (state_r)
      pai_pkg::S_IDLE: begin
        if (start) begin
          rect_nxt = '0;
          trap_nxt = '0;
          sat_nxt  = 1'b0;
          zero_nxt = (item.steps == '0);
          n_nxt    = item.steps;
          lo_nxt   = item.lower;
        end
      end
      pai_pkg::S_DIV: begin
        if (div_rsp.done) begin
          dx_nxt  = div_rsp.quot;
          acc_nxt = sext(lo_r) <<< FRAC_BITS;
          i_nxt   = '0;
        end
      end
      pai_pkg::S_HINIT: begin
        x_nxt = acc_r >>> FRAC_BITS;
        v_nxt = sext(coef[deg_eff]);
        d_nxt = deg_eff;
      end
      pai_pkg::S_HMUL: begin
        if (mul_rsp.done) begin
          v_nxt   = horner_add.val;
          d_nxt   = dm1;
          sat_nxt = sat_r | mul_rsp.sat | horner_add.ovf;
        end
      end
      pai_pkg::S_PT: begin
        if (i_r == '0) begin
          fprev_nxt = v_r;
          i_nxt     = SW'(1);
          acc_nxt   = acc_r + dx_r;
        end
      end
      pai_pkg::S_RMUL: begin
        if (mul_rsp.done) begin
          rect_nxt = rect_add.val;
          sat_nxt  = sat_r | mul_rsp.sat | rect_add.ovf;
        end
      end
      pai_pkg::S_TMUL: begin
        if (mul_rsp.done) begin
          trap_nxt  = trap_add.val;
          sat_nxt   = sat_r | mul_rsp.sat | trap_add.ovf;
          fprev_nxt = v_r;
          if (i_r != n_r) begin
            i_nxt   = i_r + SW'(1);
            acc_nxt = acc_r + dx_r;
          end
        end
      end
      default: begin
        sat_nxt = sat_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pai_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    dx_r    <= dx_nxt;
    x_r     <= x_nxt;
    v_r     <= v_nxt;
    fprev_r <= fprev_nxt;
    rect_r  <= rect_nxt;
    trap_r  <= trap_nxt;
    d_r     <= d_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    lo_r    <= lo_nxt;
    sat_r   <= sat_nxt;
    zero_r  <= zero_nxt;
  end

endmodule

`default_nettype wire

### sv/polynomial_area_integrator.sv
// Top level of the polynomial area integrator: configuration registers,
// input handshake and output register. Depends on pai_pkg, pai_div, pai_mul, pai_seq.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   in       | in_valid/in_ready  | in_lower_bound, in_upper_bound, in_step_count
//   out      | out_valid/out_ready| out_rect_area, out_trap_area, out_status
//   cfg      | cfg_we             | cfg_index, cfg_data
//
// One transaction first divides for the step width, then runs a Horner evaluation
// at each grid point (n + 1 of them), with the degree clamped to MAX_DEGREE, and
// for each step two more products for the area terms. All products go through
// the one shared multiplier, which sets the pace.
// Reset is synchronous and active low; no clearing pass is needed.
// in_ready is low while a transaction is in work; a result waiting in the
// output register does not stop the next transaction from being taken.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_area_integrator #(
  parameter int MAX_DEGREE = pai_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = pai_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [pai_pkg::DATA_W-1:0]   in_lower_bound,
  input  wire logic signed [pai_pkg::DATA_W-1:0]   in_upper_bound,
  input  wire logic [pai_pkg::STEP_W-1:0]          in_step_count,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pai_pkg::WIDE_W-1:0]        out_rect_area,
  output logic signed [pai_pkg::WIDE_W-1:0]        out_trap_area,
  output logic [1:0]                               out_status,
  input  wire logic                                cfg_we,
  input  wire logic [pai_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pai_pkg::DATA_W-1:0]          cfg_data
);

  logic [pai_pkg::DEG_W-1:0]                 deg_r;
  logic [MAX_DEGREE:0][pai_pkg::DATA_W-1:0]  coef_r;

  logic                                      out_valid_r;
  logic signed [pai_pkg::WIDE_W-1:0]         out_rect_r;
  logic signed [pai_pkg::WIDE_W-1:0]         out_trap_r;
  pai_pkg::status_t                          out_status_r;

  logic                                      seq_idle;
  logic                                      start;
  logic                                      res_ready;
  logic                                      load;
  pai_pkg::item_t                            item;
  pai_pkg::div_req_t                         div_req;
  pai_pkg::div_rsp_t                         div_rsp;
  pai_pkg::mul_req_t                         mul_req;
  pai_pkg::mul_rsp_t                         mul_rsp;
  pai_pkg::result_t                          res;

  assign in_ready   = seq_idle;
  assign start      = in_valid && seq_idle;
  assign item.lower = in_lower_bound;
  assign item.upper = in_upper_bound;
  assign item.steps = in_step_count;
  assign res_ready  = !out_valid_r || out_ready;
  assign load       = res.valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r  <= '0;
      coef_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pai_pkg::REG_DEGREE) begin
        deg_r <= cfg_data[pai_pkg::DEG_W-1:0];
      end
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        if (int'(cfg_index) == int'(pai_pkg::REG_COEF0) + k) begin
          coef_r[k] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rect_r   <= res.rect;
      out_trap_r   <= res.trap;
      out_status_r <= res.status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rect_area = out_rect_r;
  assign out_trap_area = out_trap_r;
  assign out_status    = out_status_r;

  pai_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  pai_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  pai_seq #(
    .MAX_DEGREE(MAX_DEGREE),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .item       (item),
    .poly_degree(deg_r),
    .coef       (coef_r),
    .idle       (seq_idle),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .res        (res),
    .res_ready  (res_ready)
  );

endmodule

`default_nettype wire
